FILE: sv/u8cc_pkg.sv
// ----------------------------------------------------------------------------
// u8cc_pkg
// Shared types and constants for the UTF-8 code point codec.
// ----------------------------------------------------------------------------
`default_nettype none

package u8cc_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned CNT_W = 3;

    // command codes
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    // byte range limits
    localparam logic [7:0] HEAD1_MAX = 8'h7F;
    localparam logic [7:0] HEAD2_MIN = 8'hC0;
    localparam logic [7:0] HEAD2_MAX = 8'hDF;
    localparam logic [7:0] HEAD3_MIN = 8'hE0;
    localparam logic [7:0] HEAD3_MAX = 8'hEF;
    localparam logic [7:0] HEAD4_MIN = 8'hF0;
    localparam logic [7:0] HEAD4_MAX = 8'hF4;
    localparam logic [7:0] TAIL_MIN  = 8'h80;
    localparam logic [7:0] TAIL_MAX  = 8'hBF;

    // lead and tail markers for encode
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] TAIL  = 8'h80;

    // code point thresholds
    localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_BMP   = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_LEN3  = 21'h000800;
    localparam logic [CP_W-1:0] CP_LEN2  = 21'h000080;

    // sequence lengths
    localparam logic [CNT_W-1:0] LEN_0 = 3'd0;
    localparam logic [CNT_W-1:0] LEN_1 = 3'd1;
    localparam logic [CNT_W-1:0] LEN_2 = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3 = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4 = 3'd4;

    typedef struct packed {
        logic             command;
        logic [CNT_W-1:0] byte_count;
        logic [7:0]       in_byte0;
        logic [7:0]       in_byte1;
        logic [7:0]       in_byte2;
        logic [7:0]       in_byte3;
        logic [CP_W-1:0]  code_in;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] seq_length;
        logic [7:0]       out_byte0;
        logic [7:0]       out_byte1;
        logic [7:0]       out_byte2;
        logic [7:0]       out_byte3;
        logic [CP_W-1:0]  code_out;
    } t_rsp;

endpackage

`default_nettype wire

FILE: sv/u8cc_decode.sv
// ----------------------------------------------------------------------------
// u8cc_decode
// Checks a window of up to four bytes and assembles the code point.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cc_decode (
    input  wire u8cc_pkg::t_req i_req,
    output u8cc_pkg::t_rsp      o_rsp
);

    logic [7:0] b0, b1, b2, b3;
    logic       t1, t2, t3;
    logic       cnt1, cnt2, cnt3, cnt4;
    logic       hit1, hit2, hit3, hit4;

    assign b0 = i_req.in_byte0;
    assign b1 = i_req.in_byte1;
    assign b2 = i_req.in_byte2;
    assign b3 = i_req.in_byte3;

    assign t1 = (b1 >= u8cc_pkg::TAIL_MIN) && (b1 <= u8cc_pkg::TAIL_MAX);
    assign t2 = (b2 >= u8cc_pkg::TAIL_MIN) && (b2 <= u8cc_pkg::TAIL_MAX);
    assign t3 = (b3 >= u8cc_pkg::TAIL_MIN) && (b3 <= u8cc_pkg::TAIL_MAX);

    // counts above four behave as four, so plain >= compares are enough
    assign cnt1 = i_req.byte_count >= u8cc_pkg::LEN_1;
    assign cnt2 = i_req.byte_count >= u8cc_pkg::LEN_2;
    assign cnt3 = i_req.byte_count >= u8cc_pkg::LEN_3;
    assign cnt4 = i_req.byte_count >= u8cc_pkg::LEN_4;

    assign hit1 = cnt1 && (b0 <= u8cc_pkg::HEAD1_MAX);
    assign hit2 = cnt2 && (b0 >= u8cc_pkg::HEAD2_MIN) && (b0 <= u8cc_pkg::HEAD2_MAX) && t1;
    assign hit3 = cnt3 && (b0 >= u8cc_pkg::HEAD3_MIN) && (b0 <= u8cc_pkg::HEAD3_MAX)
                  && t1 && t2;
    assign hit4 = cnt4 && (b0 >= u8cc_pkg::HEAD4_MIN) && (b0 <= u8cc_pkg::HEAD4_MAX)
                  && t1 && t2 && t3;

    always_comb begin
        o_rsp = '0;
        if (hit1) begin
            o_rsp.seq_length = u8cc_pkg::LEN_1;
            o_rsp.code_out   = {14'd0, b0[6:0]};
        end else if (hit2) begin
            o_rsp.seq_length = u8cc_pkg::LEN_2;
            o_rsp.code_out   = {10'd0, b0[4:0], b1[5:0]};
        end else if (hit3) begin
            o_rsp.seq_length = u8cc_pkg::LEN_3;
            o_rsp.code_out   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        end else if (hit4) begin
            o_rsp.seq_length = u8cc_pkg::LEN_4;
            o_rsp.code_out   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        end
        o_rsp.ok = hit1 || hit2 || hit3 || hit4;
    end

endmodule

`default_nettype wire

FILE: sv/u8cc_encode.sv
// ----------------------------------------------------------------------------
// u8cc_encode
// Splits a code point into one to four UTF-8 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cc_encode (
    input  wire u8cc_pkg::t_req i_req,
    output u8cc_pkg::t_rsp      o_rsp
);

    logic [u8cc_pkg::CP_W-1:0] cp;

    assign cp = i_req.code_in;

    always_comb begin
        o_rsp = '0;
        if (cp <= u8cc_pkg::CP_MAX) begin
            o_rsp.ok = 1'b1;
            if (cp > u8cc_pkg::CP_BMP) begin
                o_rsp.seq_length = u8cc_pkg::LEN_4;
                o_rsp.out_byte0  = u8cc_pkg::LEAD4 | {5'd0, cp[20:18]};
                o_rsp.out_byte1  = u8cc_pkg::TAIL  | {2'd0, cp[17:12]};
                o_rsp.out_byte2  = u8cc_pkg::TAIL  | {2'd0, cp[11:6]};
                o_rsp.out_byte3  = u8cc_pkg::TAIL  | {2'd0, cp[5:0]};
            end else if (cp >= u8cc_pkg::CP_LEN3) begin
                o_rsp.seq_length = u8cc_pkg::LEN_3;
                o_rsp.out_byte0  = u8cc_pkg::LEAD3 | {4'd0, cp[15:12]};
                o_rsp.out_byte1  = u8cc_pkg::TAIL  | {2'd0, cp[11:6]};
                o_rsp.out_byte2  = u8cc_pkg::TAIL  | {2'd0, cp[5:0]};
            end else if (cp >= u8cc_pkg::CP_LEN2) begin
                o_rsp.seq_length = u8cc_pkg::LEN_2;
                o_rsp.out_byte0  = u8cc_pkg::LEAD2 | {3'd0, cp[10:6]};
                o_rsp.out_byte1  = u8cc_pkg::TAIL  | {2'd0, cp[5:0]};
            end else begin
                o_rsp.seq_length = u8cc_pkg::LEN_1;
                o_rsp.out_byte0  = {1'b0, cp[6:0]};
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/utf8_codepoint_codec_core.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_codec_core
// UTF-8 decode / encode of one request per beat, two register stages.
// ----------------------------------------------------------------------------
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------
//  request  | i_in_valid   | o_in_stall   | i_in_data  (t_req)
//  result   | o_out_valid  | i_out_stall  | o_out_data (t_rsp)
//
//  Each request beat lands in the input register, goes through the decode
//  and encode logic and is captured in the result register. One beat per
//  cycle is sustained while i_out_stall stays low. Each stage loads whenever
//  it is empty or its content moves on, so a new beat is taken while a
//  finished result still waits under i_out_stall if the input register is
//  empty. Synchronous active-low reset clears only the stage valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_codec_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire u8cc_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output u8cc_pkg::t_rsp      o_out_data
);

    // input stage
    logic           r_in_vld;
    u8cc_pkg::t_req r_in_req;

    // result stage
    logic           r_out_vld;
    u8cc_pkg::t_rsp r_out_rsp;

    logic           out_free;   // result register can take a new value
    logic           in_move;    // input register content moves to result
    logic           in_free;    // input register can take a new beat

    u8cc_pkg::t_rsp dec_rsp;
    u8cc_pkg::t_rsp enc_rsp;
    u8cc_pkg::t_rsp n_out_rsp;

    assign out_free = !r_out_vld || !i_out_stall;
    assign in_move  = r_in_vld && out_free;
    assign in_free  = !r_in_vld || out_free;

    assign o_in_stall  = !in_free;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_rsp;

    u8cc_decode u_decode (
        .i_req (r_in_req),
        .o_rsp (dec_rsp)
    );

    u8cc_encode u_encode (
        .i_req (r_in_req),
        .o_rsp (enc_rsp)
    );

    // each path zeros the fields it does not own, so a plain select is enough
    assign n_out_rsp = (r_in_req.command == u8cc_pkg::CMD_ENCODE) ? enc_rsp : dec_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_free) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_req <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a rejected request leaves an all-zero result
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_rsp.ok) |->
            (r_out_rsp.seq_length == u8cc_pkg::LEN_0 && r_out_rsp.code_out == '0 &&
             r_out_rsp.out_byte0 == 8'd0 && r_out_rsp.out_byte3 == 8'd0))
        else $error("rejected result carries nonzero payload");

    // an accepted result always has a length of one to four
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_rsp.ok) |->
            (r_out_rsp.seq_length != u8cc_pkg::LEN_0 &&
             r_out_rsp.seq_length <= u8cc_pkg::LEN_4))
        else $error("accepted result with bad length");

    // the input stage only pushes back while it holds a beat
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld))
        else $error("input stall without a held beat");

    // a beat that leaves the input stage shows up as a result next cycle
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move |=> r_out_vld)
        else $error("moved beat lost before the result register");

endmodule

`default_nettype wire

FILE: dv/utf8_codepoint_codec_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_codepoint_codec_core_tb
// Self-checking bench for the UTF-8 decode / encode core. Request beats are
// predicted on accept and each result beat is compared field by field with
// the oldest prediction. The run has a directed part, then random streams of
// well-formed windows, code points, broken windows and noise. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------

module utf8_codepoint_codec_core_tb;

    import u8cc_pkg::*;

    localparam int  HOLD_CYCLES  = 40;     // long output stall, fills the pipe
    localparam int  SETTLE_CYCLES = 10;    // extra wait after the final drain, with margin
    localparam int  MAX_REPORTS  = 200;    // keeps the log readable on a bad run
    localparam int  RANDOM_BLOCKS = 13;    // blocks of 100 random beats
    localparam int  QUIET_ITEMS  = 200;    // tail of the run with no idling
    localparam real RUN_LIMIT_NS = 2_000_000.0;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_req in_data;
    logic out_valid;
    logic out_stall;
    t_rsp out_data;

    // Shared between the driving processes.
    bit calm;             // no idling on either side while set
    bit long_hold_req;    // asks the result side for one long stall

    // ------------------------------------------------------------------------
    // Expected results, predicted at request accept
    // ------------------------------------------------------------------------
    class codec_scoreboard;
        t_rsp        expected_rsp_q[$];
        int unsigned errors;

        function bit is_tail(logic [7:0] b);
            return b[7:6] == 2'b10;
        endfunction

        // What the core must answer for one request beat.
        function t_rsp codec_result(t_req r);
            t_rsp        rsp;
            logic [2:0]  n;
            logic [20:0] cp;
            rsp = '0;
            // counts above four behave as four
            n  = (r.byte_count > 3'd4) ? 3'd4 : r.byte_count;
            cp = r.code_in;
            if (r.command == CMD_DECODE) begin
                // forms tried shortest first; overlong, surrogate and
                // beyond-range four-byte forms all pass
                if (n >= 3'd1 && r.in_byte0[7] == 1'b0) begin
                    rsp.seq_length = LEN_1;
                    rsp.code_out   = {13'd0, r.in_byte0};
                end else if (n >= 3'd2 && r.in_byte0[7:5] == 3'b110
                             && is_tail(r.in_byte1)) begin
                    rsp.seq_length = LEN_2;
                    rsp.code_out   = {10'd0, r.in_byte0[4:0], r.in_byte1[5:0]};
                end else if (n >= 3'd3 && r.in_byte0[7:4] == 4'b1110
                             && is_tail(r.in_byte1) && is_tail(r.in_byte2)) begin
                    rsp.seq_length = LEN_3;
                    rsp.code_out   = {5'd0, r.in_byte0[3:0], r.in_byte1[5:0],
                                      r.in_byte2[5:0]};
                end else if (n >= 3'd4 && r.in_byte0 >= 8'hF0 && r.in_byte0 <= 8'hF4
                             && is_tail(r.in_byte1) && is_tail(r.in_byte2)
                             && is_tail(r.in_byte3)) begin
                    rsp.seq_length = LEN_4;
                    rsp.code_out   = {r.in_byte0[2:0], r.in_byte1[5:0],
                                      r.in_byte2[5:0], r.in_byte3[5:0]};
                end
                rsp.ok = (rsp.seq_length != LEN_0);
            end else if (cp <= 21'h10FFFF) begin
                rsp.ok = 1'b1;
                if (cp > 21'h00FFFF) begin
                    rsp.seq_length = LEN_4;
                    rsp.out_byte0  = {5'b11110, cp[20:18]};
                    rsp.out_byte1  = {2'b10, cp[17:12]};
                    rsp.out_byte2  = {2'b10, cp[11:6]};
                    rsp.out_byte3  = {2'b10, cp[5:0]};
                end else if (cp >= 21'h000800) begin
                    rsp.seq_length = LEN_3;
                    rsp.out_byte0  = {4'b1110, cp[15:12]};
                    rsp.out_byte1  = {2'b10, cp[11:6]};
                    rsp.out_byte2  = {2'b10, cp[5:0]};
                end else if (cp >= 21'h000080) begin
                    rsp.seq_length = LEN_2;
                    rsp.out_byte0  = {3'b110, cp[10:6]};
                    rsp.out_byte1  = {2'b10, cp[5:0]};
                end else begin
                    rsp.seq_length = LEN_1;
                    rsp.out_byte0  = cp[7:0];
                end
            end
            return rsp;
        endfunction

        function void note_request(t_req r);
            expected_rsp_q.push_back(codec_result(r));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_rsp_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: result beat with none expected, expected none actual %p",
                             $time, got);
                return;
            end
            want = expected_rsp_q.pop_front();
            compare_field("ok",         want.ok,         got.ok);
            compare_field("seq_length", want.seq_length, got.seq_length);
            compare_field("out_byte0",  want.out_byte0,  got.out_byte0);
            compare_field("out_byte1",  want.out_byte1,  got.out_byte1);
            compare_field("out_byte2",  want.out_byte2,  got.out_byte2);
            compare_field("out_byte3",  want.out_byte3,  got.out_byte3);
            compare_field("code_out",   want.code_out,   got.code_out);
        endfunction
    endclass

    codec_scoreboard scoreboard = new();

    // ------------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------------
    utf8_codepoint_codec_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] tail_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Anything but a continuation byte.
    function automatic logic [7:0] non_tail_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h00, 8'h7F));
        return 8'($urandom_range(8'hC0, 8'hFF));
    endfunction

    // Fully random beat; also the base for the others, so fields that a
    // command ignores still toggle.
    function automatic t_req noise_request();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_req)-1:0];
    endfunction

    function automatic t_req decode_request(int unsigned cnt, logic [7:0] b0,
                                            logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3);
        t_req r;
        r            = noise_request();
        r.command    = CMD_DECODE;
        r.byte_count = 3'(cnt);
        r.in_byte0   = b0;
        r.in_byte1   = b1;
        r.in_byte2   = b2;
        r.in_byte3   = b3;
        return r;
    endfunction

    function automatic t_req encode_request(int unsigned cp);
        t_req r;
        r         = noise_request();
        r.command = CMD_ENCODE;
        r.code_in = 21'(cp);
        return r;
    endfunction

    // Mostly well-formed windows and in-range code points with random
    // content; the rest is broken windows, out-of-range code points and noise.
    function automatic t_req random_request();
        t_req        r;
        int unsigned kind;
        int unsigned len;
        int unsigned pick;
        logic [7:0]  head;
        kind = $urandom_range(0, 99);
        r    = noise_request();
        if (kind < 55) begin
            len = $urandom_range(1, 4);
            case (len)
                1:       head = 8'($urandom_range(8'h00, 8'h7F));
                2:       head = 8'($urandom_range(8'hC0, 8'hDF));
                3:       head = 8'($urandom_range(8'hE0, 8'hEF));
                default: head = 8'($urandom_range(8'hF0, 8'hF4));
            endcase
            r = decode_request($urandom_range(len, 7), head,
                               tail_byte(), tail_byte(), tail_byte());
            if (kind >= 40) begin
                // break it: short count, bad continuation or bad head
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    r.byte_count = 3'($urandom_range(0, len - 1));
                end else if (pick == 1 && len > 1) begin
                    case ($urandom_range(1, len - 1))
                        1:       r.in_byte1 = non_tail_byte();
                        2:       r.in_byte2 = non_tail_byte();
                        default: r.in_byte3 = non_tail_byte();
                    endcase
                end else if ($urandom_range(0, 1) == 0) begin
                    r.in_byte0 = 8'($urandom_range(8'h80, 8'hBF));
                end else begin
                    r.in_byte0 = 8'($urandom_range(8'hF5, 8'hFF));
                end
            end
        end else if (kind < 88) begin
            case ($urandom_range(0, 4))
                0:       r = encode_request($urandom_range(21'h000000, 21'h00007F));
                1:       r = encode_request($urandom_range(21'h000080, 21'h0007FF));
                2:       r = encode_request($urandom_range(21'h000800, 21'h00FFFF));
                3:       r = encode_request($urandom_range(21'h010000, 21'h10FFFF));
                default: r = encode_request($urandom_range(21'h00D800, 21'h00DFFF));
            endcase
        end else if (kind < 94) begin
            r = encode_request($urandom_range(21'h110000, 21'h1FFFFF));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Occasional random idle gap before a beat unless calm is set, junk payload while idle.
    task automatic request_gap();
        int unsigned n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 5);
            @(negedge clk);
            in_valid <= 1'b0;
            in_data  <= noise_request();
            repeat (n) @(posedge clk);
        end
    endtask

    // Offer one beat and hold it until the core takes it.
    task automatic send_request(input t_req r);
        request_gap();
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
        scoreboard.note_request(r);
    endtask

    // Drop valid and wait for every predicted result to show up.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scoreboard.expected_rsp_q.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Values before the edge are what the core saw.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            scoreboard.check_result(out_data);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_req directed_q[$];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        calm          = 1'b0;
        long_hold_req = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed: field extremes and the named corner cases ---
        directed_q.push_back(decode_request(1, 8'h00, 8'h00, 8'h00, 8'h00));
        directed_q.push_back(decode_request(1, 8'h7F, 8'hFF, 8'hFF, 8'hFF));
        // overlong two-byte form decodes to zero
        directed_q.push_back(decode_request(2, 8'hC0, 8'h80, 8'h00, 8'h00));
        directed_q.push_back(decode_request(2, 8'hDF, 8'hBF, 8'h00, 8'h00));
        // surrogate window is accepted
        directed_q.push_back(decode_request(3, 8'hED, 8'hA0, 8'h80, 8'h00));
        directed_q.push_back(decode_request(3, 8'hEF, 8'hBF, 8'hBF, 8'h00));
        directed_q.push_back(decode_request(4, 8'hF0, 8'h80, 8'h80, 8'h80));
        // four-byte form past the Unicode range still decodes
        directed_q.push_back(decode_request(4, 8'hF4, 8'hBF, 8'hBF, 8'hBF));
        directed_q.push_back(decode_request(4, 8'hF5, 8'h80, 8'h80, 8'h80));
        // empty window
        directed_q.push_back(decode_request(0, 8'h41, 8'h00, 8'h00, 8'h00));
        // count above four
        directed_q.push_back(decode_request(7, 8'hE2, 8'h82, 8'hAC, 8'hFF));
        directed_q.push_back(decode_request(5, 8'hF4, 8'h8F, 8'hBF, 8'hBF));
        // truncated window, bad continuation, stray continuation as head
        directed_q.push_back(decode_request(1, 8'hC3, 8'hA9, 8'h00, 8'h00));
        directed_q.push_back(decode_request(2, 8'hC3, 8'h41, 8'h00, 8'h00));
        directed_q.push_back(decode_request(4, 8'h80, 8'h80, 8'h80, 8'h80));
        directed_q.push_back(decode_request(6, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // encode at every length boundary
        directed_q.push_back(encode_request(21'h000000));
        directed_q.push_back(encode_request(21'h00007F));
        directed_q.push_back(encode_request(21'h000080));
        directed_q.push_back(encode_request(21'h0007FF));
        directed_q.push_back(encode_request(21'h000800));
        directed_q.push_back(encode_request(21'h00FFFF));
        directed_q.push_back(encode_request(21'h010000));
        directed_q.push_back(encode_request(21'h10FFFF));
        // surrogate encodes normally; out of range is rejected
        directed_q.push_back(encode_request(21'h00D800));
        directed_q.push_back(encode_request(21'h110000));
        directed_q.push_back(encode_request(21'h1FFFFF));
        foreach (directed_q[i])
            send_request(directed_q[i]);

        // request side pauses until the pipe is empty
        drain_results();

        // --- long result stall while requests keep coming: input backs up ---
        calm          = 1'b1;
        long_hold_req = 1'b1;
        repeat (30) send_request(random_request());
        calm = 1'b0;

        // --- random traffic; some blocks run without idling ---
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            calm = ($urandom_range(0, 3) == 0);
            repeat (100) send_request(random_request());
        end

        // --- back-to-back tail, no idling either side ---
        calm = 1'b1;
        repeat (QUIET_ITEMS) send_request(random_request());

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (scoreboard.errors == 0 && scoreboard.expected_rsp_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
